@@ rtl/core/okt_pkg.sv @@
// shared types, constants and codes of the observed key table
package okt_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CMP_W   = (CNT_W > 6) ? CNT_W : 6;

   localparam logic [32:0] HZ_MAX   = 33'd6000000000;
   localparam logic [15:0] NC_MAX   = 16'h0fff;
   localparam logic [15:0] GID_BAD  = 16'hffff;
   localparam logic [7:0]  SRC_BITS = 8'h07;
   localparam logic [31:0] HITS_MAX = 32'hffff_ffff;

   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_CLEAR  = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [32:0] carrier_hz;
      logic [15:0] network_code;
      logic [15:0] group_id;
      logic [7:0]  source_mask;
      logic [31:0] now_ms;
      logic [5:0]  read_index;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [5:0]  row_number;
      logic        row_valid;
      logic [32:0] row_carrier_hz;
      logic [11:0] row_network_code;
      logic [15:0] row_group_id;
      logic [31:0] row_hits;
      logic [2:0]  row_sources;
      logic [31:0] row_last_seen;
      logic [6:0]  used_count;
      logic [31:0] generation_now;
   } rsp_type;

   typedef struct packed {
      logic [32:0] hz;
      logic [11:0] nc;
      logic [15:0] gid;
      logic [31:0] hits;
      logic [2:0]  srcs;
      logic [31:0] seen;
   } row_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RDWAIT,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_REFUSE,
      OP_READ_ISSUE,
      OP_READ_DONE,
      OP_SCAN_START,
      OP_SCAN_STEP,
      OP_UPDATE
   } op_type;

   typedef enum logic [1:0] {
      KIND_RECORD,
      KIND_CLEAR,
      KIND_READ,
      KIND_REFUSE
   } kind_type;

   typedef struct packed {
      logic   latch_req;
      op_type op;
      logic   load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     scan_done;
      logic     rsp_free;
   } ctrl_sts_type;

endpackage

@@ rtl/core/okt_ram.sv @@
// generic single write port ram with registered read
module okt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/okt_ctrl.sv @@
// controller state machine of the observed key table
module okt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  okt_pkg::ctrl_sts_type sts,
   output okt_pkg::ctrl_cmd_type cmd
);
   import okt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.latch_req = 1'b0;
      cmd.op        = OP_NONE;
      cmd.load_rsp  = 1'b0;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.kind)
               KIND_CLEAR: begin
                  cmd.op   = OP_CLEAR;
                  state_in = ST_RESP;
               end
               KIND_READ: begin
                  cmd.op   = OP_READ_ISSUE;
                  state_in = ST_RDWAIT;
               end
               KIND_RECORD: begin
                  cmd.op   = OP_SCAN_START;
                  state_in = ST_SCAN;
               end
               default: begin
                  cmd.op   = OP_REFUSE;
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_RDWAIT: begin
            cmd.op   = OP_READ_DONE;
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               cmd.op   = OP_UPDATE;
               state_in = ST_RESP;
            end else begin
               cmd.op = OP_SCAN_STEP;
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/okt_dp.sv @@
// datapath of the observed key table: row ram, scan, update and result register
module okt_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  okt_pkg::req_type      req_data,
   input  okt_pkg::ctrl_cmd_type cmd,
   output okt_pkg::ctrl_sts_type sts,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output okt_pkg::rsp_type      rsp_data
);
   import okt_pkg::*;

   req_type           req_ff;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [31:0]       gen_ff, gen_in;
   logic [CNT_W-1:0]  issue_ptr_ff, issue_ptr_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              match_found_ff, match_found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic [31:0]       match_hits_ff, match_hits_in;
   logic [2:0]        match_srcs_ff, match_srcs_in;
   logic [31:0]       best_age_ff, best_age_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   row_type           ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   row_type           ram_rd_data;

   logic              rec_ok;
   logic              key_hit;
   logic [31:0]       age;
   logic              rd_in_range;
   logic [IDX_W-1:0]  tgt_idx;
   logic              tgt_append;
   logic [31:0]       base_hits;
   logic [2:0]        base_srcs;
   row_type           new_row;
   logic [CNT_W-1:0]  used_next;

   okt_ram #(
      .WIDTH ($bits(row_type)),
      .DEPTH (ENTRIES)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // record key and source checks
   assign rec_ok = (req_ff.carrier_hz != 33'd0) && (req_ff.carrier_hz <= HZ_MAX) &&
                   (req_ff.network_code <= NC_MAX) && (req_ff.group_id != 16'd0) &&
                   (req_ff.group_id != GID_BAD) &&
                   ((req_ff.source_mask & SRC_BITS) != 8'd0) &&
                   ((req_ff.source_mask & ~SRC_BITS) == 8'd0);

   always_comb begin
      sts.scan_done = (issue_ptr_ff == used_ff) && !cmp_valid_ff;
      sts.rsp_free  = !rsp_valid_ff || !rsp_stall;
      case (req_ff.cmd)
         CMD_CLEAR:  sts.kind = KIND_CLEAR;
         CMD_READ:   sts.kind = KIND_READ;
         CMD_RECORD: sts.kind = rec_ok ? KIND_RECORD : KIND_REFUSE;
         default:    sts.kind = KIND_REFUSE;
      endcase
   end

   assign key_hit = (ram_rd_data.hz == req_ff.carrier_hz) &&
                    (ram_rd_data.nc == req_ff.network_code[11:0]) &&
                    (ram_rd_data.gid == req_ff.group_id);
   assign age = req_ff.now_ms - ram_rd_data.seen;
   assign rd_in_range = CMP_W'(req_ff.read_index) < CMP_W'(used_ff);

   // row chosen by a record
   always_comb begin
      if (match_found_ff) begin
         tgt_idx    = match_idx_ff;
         tgt_append = 1'b0;
         base_hits  = match_hits_ff;
         base_srcs  = match_srcs_ff;
      end else if (used_ff < CNT_W'(ENTRIES)) begin
         tgt_idx    = used_ff[IDX_W-1:0];
         tgt_append = 1'b1;
         base_hits  = 32'd0;
         base_srcs  = 3'd0;
      end else begin
         tgt_idx    = best_idx_ff;
         tgt_append = 1'b0;
         base_hits  = 32'd0;
         base_srcs  = 3'd0;
      end
      new_row.hz   = req_ff.carrier_hz;
      new_row.nc   = req_ff.network_code[11:0];
      new_row.gid  = req_ff.group_id;
      new_row.hits = (base_hits == HITS_MAX) ? HITS_MAX : base_hits + 32'd1;
      new_row.srcs = base_srcs | req_ff.source_mask[2:0];
      new_row.seen = req_ff.now_ms;
      used_next    = used_ff + CNT_W'(tgt_append);
   end

   always_comb begin
      used_in        = used_ff;
      gen_in         = gen_ff;
      issue_ptr_in   = issue_ptr_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_hits_in  = match_hits_ff;
      match_srcs_in  = match_srcs_ff;
      best_age_in    = best_age_ff;
      best_idx_in    = best_idx_ff;
      res_in         = res_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = tgt_idx;
      ram_wr_data    = new_row;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = issue_ptr_ff[IDX_W-1:0];

      case (cmd.op)
         OP_CLEAR: begin
            used_in               = '0;
            gen_in                = gen_ff + 32'd1;
            res_in                = '0;
            res_in.accepted       = 1'b1;
            res_in.used_count     = 7'd0;
            res_in.generation_now = gen_ff + 32'd1;
         end
         OP_REFUSE: begin
            res_in                = '0;
            res_in.used_count     = 7'(used_ff);
            res_in.generation_now = gen_ff;
         end
         OP_READ_ISSUE: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = IDX_W'(req_ff.read_index);
         end
         OP_READ_DONE: begin
            res_in                = '0;
            res_in.accepted       = 1'b1;
            res_in.row_number     = req_ff.read_index;
            res_in.used_count     = 7'(used_ff);
            res_in.generation_now = gen_ff;
            if (rd_in_range) begin
               res_in.row_valid        = 1'b1;
               res_in.row_carrier_hz   = ram_rd_data.hz;
               res_in.row_network_code = ram_rd_data.nc;
               res_in.row_group_id     = ram_rd_data.gid;
               res_in.row_hits         = ram_rd_data.hits;
               res_in.row_sources      = ram_rd_data.srcs;
               res_in.row_last_seen    = ram_rd_data.seen;
            end
         end
         OP_SCAN_START: begin
            issue_ptr_in   = '0;
            match_found_in = 1'b0;
         end
         OP_SCAN_STEP: begin
            if (issue_ptr_ff < used_ff) begin
               ram_rd_en    = 1'b1;
               issue_ptr_in = issue_ptr_ff + CNT_W'(1);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_ptr_ff[IDX_W-1:0];
            end
            if (cmp_valid_ff) begin
               if (!match_found_ff && key_hit) begin
                  match_found_in = 1'b1;
                  match_idx_in   = cmp_idx_ff;
                  match_hits_in  = ram_rd_data.hits;
                  match_srcs_in  = ram_rd_data.srcs;
               end
               if ((cmp_idx_ff == '0) || (age > best_age_ff)) begin
                  best_age_in = age;
                  best_idx_in = cmp_idx_ff;
               end
            end
         end
         OP_UPDATE: begin
            ram_wr_en               = 1'b1;
            used_in                 = used_next;
            gen_in                  = gen_ff + 32'd1;
            res_in.accepted         = 1'b1;
            res_in.row_number       = 6'(tgt_idx);
            res_in.row_valid        = 1'b1;
            res_in.row_carrier_hz   = new_row.hz;
            res_in.row_network_code = new_row.nc;
            res_in.row_group_id     = new_row.gid;
            res_in.row_hits         = new_row.hits;
            res_in.row_sources      = new_row.srcs;
            res_in.row_last_seen    = new_row.seen;
            res_in.used_count       = 7'(used_next);
            res_in.generation_now   = gen_ff + 32'd1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         gen_ff       <= '0;
         issue_ptr_ff <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         gen_ff       <= gen_in;
         issue_ptr_ff <= issue_ptr_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= res_ff;
      end
      cmp_idx_ff     <= cmp_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_hits_ff  <= match_hits_in;
      match_srcs_ff  <= match_srcs_in;
      best_age_ff    <= best_age_in;
      best_idx_ff    <= best_idx_in;
      res_ff         <= res_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/observed_key_table_lru_evict_unit.sv @@
// top level of the observed key table with least recently used eviction
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  okt_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall  okt_pkg::rsp_type
//
// one command at a time; a record walks every used row once through the single read
// port of the row ram, 64 rows on a full table
// reset clears the used count and generation; the row ram needs no clearing pass
// a result waits in the output register under rsp_stall while the next beat is taken
module observed_key_table_lru_evict_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  okt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output okt_pkg::rsp_type rsp_data
);
   import okt_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   ctrl_sts_type ctrl_sts;

   okt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (ctrl_sts),
      .cmd       (ctrl_cmd)
   );

   okt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (ctrl_cmd),
      .sts       (ctrl_sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat taken while a command is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_rsp |-> ctrl_sts.rsp_free)
      else $error("result register loaded over a pending beat");

   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !ctrl_cmd.load_rsp) |=> !rsp_valid)
      else $error("result beat repeated");

   a_update_after_scan: assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.op == OP_UPDATE) |-> ctrl_sts.scan_done)
      else $error("row written before the scan finished");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the observed key table with least recently used eviction
module testbench;
   import okt_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam int         DRAIN_CYCLES = 80;
   localparam int         KEY_POOL     = 96;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   row_type     known_rows [ENTRIES];
   int          rows_in_use = 0;
   logic [31:0] generation  = '0;
   rsp_type     answers_due [$];

   logic [31:0] clock_ms = '0;
   logic [32:0] pool_hz  [KEY_POOL];
   logic [15:0] pool_nc  [KEY_POOL];
   logic [15:0] pool_gid [KEY_POOL];

   bit steady_flow    = 1'b0;
   int stall_hold     = 0;
   int mismatch_count = 0;
   int results_seen   = 0;
   int cycle_count    = 0;

   observed_key_table_lru_evict_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // table behavior: update the known rows and work out the answer of one command
   function automatic rsp_type apply_table_command(input req_type beat);
      rsp_type     res;
      int          slot;
      logic [31:0] age;
      logic [31:0] age_max;
      res  = '0;
      slot = 0;
      case (beat.cmd)
         CMD_CLEAR: begin
            rows_in_use  = 0;
            generation   = generation + 32'd1;
            res.accepted = 1'b1;
         end
         CMD_READ: begin
            res.accepted   = 1'b1;
            res.row_number = beat.read_index;
            if (int'(beat.read_index) < rows_in_use) begin
               res.row_valid = 1'b1;
               slot          = int'(beat.read_index);
            end
         end
         CMD_RECORD: begin
            if (beat.carrier_hz != 33'd0 && beat.carrier_hz <= HZ_MAX &&
                beat.network_code <= NC_MAX && beat.group_id != 16'd0 &&
                beat.group_id != GID_BAD && (beat.source_mask & SRC_BITS) != 8'd0 &&
                (beat.source_mask & ~SRC_BITS) == 8'd0) begin
               slot = rows_in_use;
               // walk down so the lowest matching row wins
               for (int i = rows_in_use - 1; i >= 0; i--) begin
                  if (known_rows[i].hz == beat.carrier_hz &&
                      known_rows[i].nc == beat.network_code[11:0] &&
                      known_rows[i].gid == beat.group_id) begin
                     slot = i;
                  end
               end
               if (slot == rows_in_use) begin
                  if (rows_in_use < ENTRIES) begin
                     rows_in_use++;
                  end else begin
                     slot    = 0;
                     age_max = beat.now_ms - known_rows[0].seen;
                     for (int i = 1; i < ENTRIES; i++) begin
                        age = beat.now_ms - known_rows[i].seen;
                        if (age > age_max) begin
                           slot    = i;
                           age_max = age;
                        end
                     end
                  end
                  known_rows[slot]     = '0;
                  known_rows[slot].hz  = beat.carrier_hz;
                  known_rows[slot].nc  = beat.network_code[11:0];
                  known_rows[slot].gid = beat.group_id;
               end
               known_rows[slot].seen = beat.now_ms;
               if (known_rows[slot].hits != HITS_MAX) begin
                  known_rows[slot].hits = known_rows[slot].hits + 32'd1;
               end
               known_rows[slot].srcs = known_rows[slot].srcs | beat.source_mask[2:0];
               generation     = generation + 32'd1;
               res.accepted   = 1'b1;
               res.row_number = 6'(slot);
               res.row_valid  = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (res.row_valid) begin
         res.row_carrier_hz   = known_rows[slot].hz;
         res.row_network_code = known_rows[slot].nc;
         res.row_group_id     = known_rows[slot].gid;
         res.row_hits         = known_rows[slot].hits;
         res.row_sources      = known_rows[slot].srcs;
         res.row_last_seen    = known_rows[slot].seen;
      end
      res.used_count     = 7'(rows_in_use);
      res.generation_now = generation;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40) begin
         $display("mismatch at result %0d: %s", results_seen, what);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            report_mismatch("result beat with no command outstanding");
         end else begin
            want = answers_due.pop_front();
            check_field("accepted", 64'(rsp_data.accepted), 64'(want.accepted));
            check_field("row_number", 64'(rsp_data.row_number), 64'(want.row_number));
            check_field("row_valid", 64'(rsp_data.row_valid), 64'(want.row_valid));
            check_field("row_carrier_hz", 64'(rsp_data.row_carrier_hz),
                        64'(want.row_carrier_hz));
            check_field("row_network_code", 64'(rsp_data.row_network_code),
                        64'(want.row_network_code));
            check_field("row_group_id", 64'(rsp_data.row_group_id),
                        64'(want.row_group_id));
            check_field("row_hits", 64'(rsp_data.row_hits), 64'(want.row_hits));
            check_field("row_sources", 64'(rsp_data.row_sources), 64'(want.row_sources));
            check_field("row_last_seen", 64'(rsp_data.row_last_seen),
                        64'(want.row_last_seen));
            check_field("used_count", 64'(rsp_data.used_count), 64'(want.used_count));
            check_field("generation_now", 64'(rsp_data.generation_now),
                        64'(want.generation_now));
         end
         results_seen++;
      end
   end

   // result side back-pressure: short bursts mostly, now and then a long one
   always @(posedge clock) begin
      if (reset || steady_flow) begin
         rsp_stall  <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_hold = $urandom_range(0, 6);
      end else if ($urandom_range(0, 9) < 6) begin
         rsp_stall  <= 1'b1;
         stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 3);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 55) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 80);
   endfunction

   function automatic req_type random_beat();
      req_type beat;
      beat.cmd          = 2'($urandom_range(0, 3));
      beat.carrier_hz   = {1'($urandom_range(0, 1)), 32'($urandom())};
      beat.network_code = 16'($urandom_range(0, 16'hffff));
      beat.group_id     = 16'($urandom_range(0, 16'hffff));
      beat.source_mask  = 8'($urandom_range(0, 255));
      beat.now_ms       = $urandom();
      beat.read_index   = 6'($urandom_range(0, 63));
      return beat;
   endfunction

   function automatic logic [31:0] next_ms();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
         clock_ms = clock_ms + $urandom_range(0, 20);
      end else if (roll < 95) begin
         clock_ms = clock_ms + $urandom_range(0, 1000000);
      end else begin
         clock_ms = $urandom();
      end
      return clock_ms;
   endfunction

   // valid stays high after a beat with no gap; the next call drives straight away
   task automatic send_beat(input req_type beat);
      int gap;
      req_data  <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      answers_due.push_back(apply_table_command(beat));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_record(input logic [32:0] hz, input logic [15:0] nc,
                              input logic [15:0] gid, input logic [7:0] src,
                              input logic [31:0] ms);
      req_type beat;
      beat              = random_beat();
      beat.cmd          = CMD_RECORD;
      beat.carrier_hz   = hz;
      beat.network_code = nc;
      beat.group_id     = gid;
      beat.source_mask  = src;
      beat.now_ms       = ms;
      send_beat(beat);
   endtask

   task automatic send_read(input logic [5:0] index);
      req_type beat;
      beat            = random_beat();
      beat.cmd        = CMD_READ;
      beat.read_index = index;
      send_beat(beat);
   endtask

   task automatic send_clear();
      req_type beat;
      beat     = random_beat();
      beat.cmd = CMD_CLEAR;
      send_beat(beat);
   endtask

   task automatic send_unknown();
      req_type beat;
      beat     = random_beat();
      beat.cmd = CMD_UNKNOWN;
      send_beat(beat);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic draw_key(output logic [32:0] hz, output logic [15:0] nc,
                           output logic [15:0] gid);
      hz = {1'($urandom_range(0, 1)), 32'($urandom())};
      if (hz == 33'd0 || hz > HZ_MAX) begin
         hz = hz % HZ_MAX + 33'd1;
      end
      nc  = 16'($urandom_range(0, NC_MAX));
      gid = 16'($urandom_range(1, GID_BAD - 16'd1));
   endtask

   task automatic send_random_record(input bit fresh);
      logic [32:0] hz;
      logic [15:0] nc;
      logic [15:0] gid;
      int          k;
      if (fresh) begin
         draw_key(hz, nc, gid);
      end else begin
         k   = $urandom_range(0, KEY_POOL - 1);
         hz  = pool_hz[k];
         nc  = pool_nc[k];
         gid = pool_gid[k];
      end
      send_record(hz, nc, gid, 8'($urandom_range(1, 7)), next_ms());
   endtask

   task automatic send_random_read();
      if (rows_in_use > 0 && $urandom_range(0, 3) != 0) begin
         send_read(6'($urandom_range(0, rows_in_use - 1)));
      end else begin
         send_read(6'($urandom_range(0, 63)));
      end
   endtask

   task automatic test_refused_records();
      send_record(33'd0, 16'd1, 16'd1, 8'h01, 32'd10);
      send_record(HZ_MAX + 33'd1, 16'd1, 16'd1, 8'h01, 32'd10);
      send_record(33'h1_ffff_ffff, 16'd1, 16'd1, 8'h01, 32'd10);
      send_record(33'd1000, NC_MAX + 16'd1, 16'd1, 8'h01, 32'd10);
      send_record(33'd1000, 16'hffff, 16'd1, 8'h01, 32'd10);
      send_record(33'd1000, 16'd1, 16'd0, 8'h01, 32'd10);
      send_record(33'd1000, 16'd1, GID_BAD, 8'h01, 32'd10);
      send_record(33'd1000, 16'd1, 16'd1, 8'h00, 32'd10);
      send_record(33'd1000, 16'd1, 16'd1, 8'h08, 32'd10);
      send_record(33'd1000, 16'd1, 16'd1, 8'hf9, 32'd10);
      send_unknown();
   endtask

   task automatic test_record_extremes();
      send_record(33'd1, 16'd0, 16'd1, 8'h01, 32'd0);
      send_record(HZ_MAX, NC_MAX, GID_BAD - 16'd1, 8'h04, 32'hffff_ffff);
      send_record(33'd1, 16'd0, 16'd1, 8'h02, 32'd5);
   endtask

   task automatic test_row_reads();
      send_read(6'd0);
      send_read(6'd1);
      send_read(6'd2);
      send_read(6'd63);
   endtask

   task automatic test_clear_table();
      send_clear();
      send_read(6'd0);
   endtask

   // pool keys often share a frequency with a neighbor so near misses are common
   task automatic test_table_eviction();
      int roll;
      for (int k = 0; k < KEY_POOL; k++) begin
         draw_key(pool_hz[k], pool_nc[k], pool_gid[k]);
         if (k > 0 && $urandom_range(0, 3) == 0) begin
            pool_hz[k] = pool_hz[k - 1];
            if ($urandom_range(0, 1)) begin
               pool_nc[k] = pool_nc[k - 1];
            end
         end
      end
      clock_ms = $urandom();
      send_clear();
      for (int n = 0; n < 160; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            send_random_record(1'b0);
         end else if (roll < 92) begin
            send_random_record(1'b1);
         end else begin
            send_random_read();
         end
      end
   endtask

   task automatic test_random_mix();
      int roll;
      for (int n = 0; n < 340; n++) begin
         steady_flow <= (n >= 120 && n < 180);
         if (n == 200) begin
            drain_results();
         end
         roll = $urandom_range(0, 199);
         if (roll < 2) begin
            send_clear();
         end else if (roll < 124) begin
            send_random_record(1'b0);
         end else if (roll < 140) begin
            send_random_record(1'b1);
         end else if (roll < 170) begin
            send_random_read();
         end else begin
            send_beat(random_beat());
         end
      end
      steady_flow <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_refused_records();
      test_record_extremes();
      test_row_reads();
      test_clear_table();
      drain_results();
      test_table_eviction();
      drain_results();
      test_random_mix();
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
